FILE: rtl/core/mme_pkg.sv
// Shared constants, codes and types of the matrix multiply engine.
package mme_pkg;

	localparam int MAX_DIM_DEF   = 16;
	localparam int ELEM_BITS_DEF = 16;

	localparam int ACTION_BITS  = 2;
	localparam int INDEX_BITS   = 4;
	localparam int VALUE_BITS   = 16;
	localparam int SUM_BITS     = 36;
	localparam int CFG_BITS     = 5;
	localparam int CFG_IDX_BITS = 2;

	localparam logic [ACTION_BITS-1:0] ACT_WRITE_A = 2'd0;
	localparam logic [ACTION_BITS-1:0] ACT_WRITE_B = 2'd1;
	localparam logic [ACTION_BITS-1:0] ACT_READ    = 2'd2;

	localparam logic [CFG_IDX_BITS-1:0] REG_ROWS_A     = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_INNER_SIZE = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_COLS_B     = 2'd2;

	localparam logic [CFG_BITS-1:0] CFG_RESET = 5'd16;

	typedef struct packed {
		logic clear;
		logic valid;
	} mac_ctrl_t;

endpackage

FILE: rtl/core/mme_if.sv
// Request and response channel interfaces of the matrix multiply engine.
interface mme_req_if;
	import mme_pkg::*;

	logic                         valid;
	logic                         ready;
	logic [ACTION_BITS-1:0]       action;
	logic [INDEX_BITS-1:0]        row_index;
	logic [INDEX_BITS-1:0]        col_index;
	logic signed [VALUE_BITS-1:0] element_value;

	modport source (output valid, action, row_index, col_index, element_value, input ready);
	modport sink (input valid, action, row_index, col_index, element_value, output ready);
endinterface

interface mme_rsp_if;
	import mme_pkg::*;

	logic                       valid;
	logic                       ready;
	logic signed [SUM_BITS-1:0] product_value;
	logic                       index_error;

	modport source (output valid, product_value, index_error, input ready);
	modport sink (input valid, product_value, index_error, output ready);
endinterface

FILE: rtl/core/mme_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mme_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: rtl/core/mme_mac.sv
// Shared multiply-accumulate unit: registered product, then a wrapping accumulator.
module mme_mac #(
	parameter int ELEM_BITS = mme_pkg::ELEM_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  mme_pkg::mac_ctrl_t                  ctrl,
	input  logic signed [ELEM_BITS-1:0]         a,
	input  logic signed [ELEM_BITS-1:0]         b,
	output logic signed [mme_pkg::SUM_BITS-1:0] acc,
	output logic                                busy
);
	import mme_pkg::*;

	logic signed [2*ELEM_BITS-1:0] prod_s2;
	logic                          valid_s2;
	logic signed [SUM_BITS-1:0]    acc_q;

	always_ff @(posedge clk) begin
		if (ctrl.valid) begin
			prod_s2 <= a * b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			acc_q    <= '0;
		end else begin
			valid_s2 <= ctrl.valid;
			if (ctrl.clear) begin
				acc_q <= '0;
			end else if (valid_s2) begin
				acc_q <= acc_q + SUM_BITS'(prod_s2);
			end
		end
	end

	assign acc  = acc_q;
	assign busy = valid_s2;

endmodule

FILE: rtl/core/matrix_multiply_engine.sv
// Top level of the matrix multiply engine: element stores, sequencer and result register.
//
// Requests arrive on req: action 0 writes an element of A, action 1 writes an
// element of B, action 2 reads element (row, col) of the product; action 3 is
// ignored. Writes give no response and leave the block ready in the next cycle.
// A read walks the inner dimension through one multiply-accumulate unit, one
// element pair per cycle, fed by two RAMs read in parallel. The response
// appears on rsp once the loop over the clamped inner size has run and the
// multiply-accumulate pipeline has drained; a read outside rows_a or cols_b
// skips the loop and returns zero with index_error set. Only one read is in
// flight, and req.ready is low until its result has moved into the output
// register. The output register lets the next request be taken while a
// response waits; if the receiver keeps rsp.ready low, a second finished read
// waits inside the block and req.ready stays low. Reset clears the control
// state and sets rows_a, inner_size and cols_b to 16; the element stores are
// not cleared and hold unknown data until written. Configuration is written on
// cfg_write with cfg_index and cfg_data; the user must write it only while no
// read is in progress, and the block itself does not enforce this.
module matrix_multiply_engine #(
	parameter int MAX_DIM   = mme_pkg::MAX_DIM_DEF,
	parameter int ELEM_BITS = mme_pkg::ELEM_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_write,
	input  logic [mme_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input  logic [mme_pkg::CFG_BITS-1:0]     cfg_data,
	mme_req_if.sink                          req,
	mme_rsp_if.source                        rsp
);
	import mme_pkg::*;

	localparam int ADDR_BITS = $clog2(MAX_DIM * MAX_DIM);
	localparam int CALC_W    = ADDR_BITS + INDEX_BITS;
	localparam int CNT_W     = ($clog2(MAX_DIM + 1) > CFG_BITS) ? $clog2(MAX_DIM + 1) : CFG_BITS;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RUN  = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	function automatic logic [ADDR_BITS-1:0] elem_addr(input logic [INDEX_BITS-1:0] r,
		input logic [INDEX_BITS-1:0] c);
		logic [CALC_W-1:0] full;
		full = CALC_W'(r) * CALC_W'(MAX_DIM) + CALC_W'(c);
		return full[ADDR_BITS-1:0];
	endfunction

	logic [CFG_BITS-1:0]         rows_a_q;
	logic [CFG_BITS-1:0]         inner_size_q;
	logic [CFG_BITS-1:0]         cols_b_q;
	logic [1:0]                  state_q;
	logic [CNT_W-1:0]            k_q;
	logic [ADDR_BITS-1:0]        addr_a_q;
	logic [ADDR_BITS-1:0]        addr_b_q;
	logic                        valid_s1;
	logic                        err_q;
	logic                        out_valid_q;
	logic signed [SUM_BITS-1:0]  product_q;
	logic                        index_error_q;

	logic                        req_fire;
	logic                        is_read;
	logic                        in_store;
	logic                        rd_oob;
	logic [CNT_W-1:0]            nr;
	logic [CNT_W-1:0]            nk;
	logic [CNT_W-1:0]            nc;
	logic                        issue;
	logic                        we_a;
	logic                        we_b;
	logic [ADDR_BITS-1:0]        waddr;
	logic [ELEM_BITS-1:0]        wdata;
	logic [ELEM_BITS-1:0]        rdata_a;
	logic [ELEM_BITS-1:0]        rdata_b;
	mac_ctrl_t                   mac_ctrl;
	logic signed [SUM_BITS-1:0]  acc;
	logic                        mac_busy;
	logic                        out_free;

	always_comb begin
		nr = (CNT_W'(rows_a_q) > CNT_W'(MAX_DIM)) ? CNT_W'(MAX_DIM) : CNT_W'(rows_a_q);
		nk = (CNT_W'(inner_size_q) > CNT_W'(MAX_DIM)) ? CNT_W'(MAX_DIM) : CNT_W'(inner_size_q);
		nc = (CNT_W'(cols_b_q) > CNT_W'(MAX_DIM)) ? CNT_W'(MAX_DIM) : CNT_W'(cols_b_q);
	end

	assign req.ready = (state_q == ST_IDLE);
	assign req_fire  = req.valid && req.ready;
	assign is_read   = (req.action == ACT_READ);
	assign in_store  = (CNT_W'(req.row_index) < CNT_W'(MAX_DIM)) &&
		(CNT_W'(req.col_index) < CNT_W'(MAX_DIM));
	assign rd_oob    = (CNT_W'(req.row_index) >= nr) || (CNT_W'(req.col_index) >= nc);
	assign we_a      = req_fire && (req.action == ACT_WRITE_A) && in_store;
	assign we_b      = req_fire && (req.action == ACT_WRITE_B) && in_store;
	assign waddr     = elem_addr(req.row_index, req.col_index);
	assign wdata     = ELEM_BITS'(req.element_value);
	assign issue     = (state_q == ST_RUN) && (k_q < nk);
	assign out_free  = !out_valid_q || rsp.ready;

	assign mac_ctrl.clear = req_fire && is_read;
	assign mac_ctrl.valid = valid_s1;

	mme_ram #(
		.WIDTH (ELEM_BITS),
		.DEPTH (MAX_DIM * MAX_DIM)
	) u_store_a (
		.clk   (clk),
		.we    (we_a),
		.waddr (waddr),
		.wdata (wdata),
		.re    (issue),
		.raddr (addr_a_q),
		.rdata (rdata_a)
	);

	mme_ram #(
		.WIDTH (ELEM_BITS),
		.DEPTH (MAX_DIM * MAX_DIM)
	) u_store_b (
		.clk   (clk),
		.we    (we_b),
		.waddr (waddr),
		.wdata (wdata),
		.re    (issue),
		.raddr (addr_b_q),
		.rdata (rdata_b)
	);

	mme_mac #(
		.ELEM_BITS (ELEM_BITS)
	) u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (mac_ctrl),
		.a      (rdata_a),
		.b      (rdata_b),
		.acc    (acc),
		.busy   (mac_busy)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_a_q     <= CFG_RESET;
			inner_size_q <= CFG_RESET;
			cols_b_q     <= CFG_RESET;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_ROWS_A:     rows_a_q     <= cfg_data;
				REG_INNER_SIZE: inner_size_q <= cfg_data;
				REG_COLS_B:     cols_b_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire && is_read) begin
			addr_a_q <= elem_addr(req.row_index, INDEX_BITS'(0));
			addr_b_q <= elem_addr(INDEX_BITS'(0), req.col_index);
		end else if (issue) begin
			addr_a_q <= addr_a_q + ADDR_BITS'(1);
			addr_b_q <= addr_b_q + ADDR_BITS'(MAX_DIM);
		end
		if (state_q == ST_DONE && out_free) begin
			product_q     <= acc;
			index_error_q <= err_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			k_q         <= '0;
			valid_s1    <= 1'b0;
			err_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			valid_s1 <= issue;
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (req_fire && is_read) begin
						k_q   <= '0;
						err_q <= rd_oob;
						state_q <= rd_oob ? ST_DONE : ST_RUN;
					end
				end
				ST_RUN: begin
					if (issue) begin
						k_q <= k_q + CNT_W'(1);
					end else if (!valid_s1 && !mac_busy) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.product_value = product_q;
	assign rsp.index_error   = index_error_q;

endmodule

FILE: rtl/core/mme_checker.sv
// Port-level checks of the matrix multiply engine and their binding to the top level.
module mme_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               req_valid,
	input logic                               req_ready,
	input logic [mme_pkg::ACTION_BITS-1:0]    req_action,
	input logic                               rsp_valid,
	input logic                               rsp_ready,
	input logic signed [mme_pkg::SUM_BITS-1:0] product_value,
	input logic                               index_error
);
	import mme_pkg::*;

	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(product_value) && $stable(index_error))
		else $error("Response changed while the receiver stalled.");

	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && index_error |-> product_value == '0)
		else $error("An out-of-range read returned a nonzero value.");

	assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && req_action == ACT_READ |=> !req_ready)
		else $error("A read request did not occupy the engine.");

	assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && req_action != ACT_READ |=> req_ready)
		else $error("A write request blocked the next request.");

endmodule

bind matrix_multiply_engine mme_checker u_mme_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.req_valid     (req.valid),
	.req_ready     (req.ready),
	.req_action    (req.action),
	.rsp_valid     (rsp.valid),
	.rsp_ready     (rsp.ready),
	.product_value (rsp.product_value),
	.index_error   (rsp.index_error)
);

FILE: bench/tb_top.sv
// Testbench of the matrix multiply engine: directed and random requests checked against a predictor.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import mme_pkg::*;

	localparam int DIM          = MAX_DIM_DEF;
	localparam int PERIOD       = 8;
	localparam int LIMIT_CYCLES = 1_000_000;
	localparam int DRAIN_CYCLES = 32;
	localparam int HOLD_AT      = 200;
	localparam int HOLD_CYCLES  = 400;

	localparam logic [ACTION_BITS-1:0] ACT_UNUSED = 2'd3;

	typedef struct packed {
		logic [ACTION_BITS-1:0]       action;
		logic [INDEX_BITS-1:0]        row;
		logic [INDEX_BITS-1:0]        col;
		logic signed [VALUE_BITS-1:0] value;
	} request_t;

	typedef struct packed {
		logic signed [SUM_BITS-1:0] product;
		logic                       index_error;
	} product_t;

	logic                    clk = 1'b0;
	logic                    arst_n;
	logic                    cfg_write;
	logic [CFG_IDX_BITS-1:0] cfg_index;
	logic [CFG_BITS-1:0]     cfg_data;

	mme_req_if req_ch ();
	mme_rsp_if rsp_ch ();

	matrix_multiply_engine dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.req      (req_ch),
		.rsp      (rsp_ch)
	);

	always #(PERIOD / 2) clk = ~clk;

	// Predictor state: element stores and the sizes as the block holds them.
	logic signed [VALUE_BITS-1:0] a_mem [DIM][DIM];
	logic signed [VALUE_BITS-1:0] b_mem [DIM][DIM];
	logic [CFG_BITS-1:0]          rows_cfg;
	logic [CFG_BITS-1:0]          inner_cfg;
	logic [CFG_BITS-1:0]          cols_cfg;

	// Elements already queued for writing, so that no read touches an unwritten one.
	bit a_filled [DIM][DIM];
	bit b_filled [DIM][DIM];

	request_t pending_requests [$];
	product_t expected_products [$];

	request_t next_req;
	product_t want;
	int       mismatch_count = 0;
	int       accepted_count;
	int       cycle_count = 0;
	bit       calm;
	int       gap_left;
	int       gap_stretch;
	bit       gaps_on;
	int       stall_left;
	int       stall_stretch;
	bit       stalls_on;
	int       hold_left;
	bit       hold_done;

	function automatic int clamp_size(logic [CFG_BITS-1:0] v);
		return (v > DIM) ? DIM : int'(v);
	endfunction

	function automatic product_t dot_product(int row, int col);
		product_t                       r;
		logic signed [SUM_BITS-1:0]     acc;
		logic signed [2*VALUE_BITS-1:0] term;
		r.product = '0;
		r.index_error = 1'b0;
		acc = '0;
		if (row >= clamp_size(rows_cfg) || col >= clamp_size(cols_cfg)) begin
			r.index_error = 1'b1;
			return r;
		end
		for (int k = 0; k < clamp_size(inner_cfg); k++) begin
			term = a_mem[row][k] * b_mem[k][col];
			acc = acc + term;
		end
		r.product = acc;
		return r;
	endfunction

	function automatic logic signed [VALUE_BITS-1:0] rand_value();
		case ($urandom_range(0, 9))
			0: return 16'sh7fff;
			1: return 16'sh8000;
			2: return 16'sh0000;
			3: return -16'sd1;
			default: return VALUE_BITS'($urandom);
		endcase
	endfunction

	function automatic int pick_index(int n);
		if (n > 0 && $urandom_range(0, 3) != 0)
			return $urandom_range(0, n - 1);
		return $urandom_range(0, DIM - 1);
	endfunction

	function automatic logic [CFG_BITS-1:0] rand_size();
		case ($urandom_range(0, 5))
			0: return 5'd0;
			1: return CFG_BITS'($urandom_range(17, 31));
			2: return 5'd1;
			default: return CFG_BITS'($urandom_range(1, 16));
		endcase
	endfunction

	task automatic push_item(logic [ACTION_BITS-1:0] act, int row, int col,
			logic signed [VALUE_BITS-1:0] value);
		request_t item;
		item.action = act;
		item.row = INDEX_BITS'(row);
		item.col = INDEX_BITS'(col);
		item.value = value;
		pending_requests.push_back(item);
		if (act == ACT_WRITE_A)
			a_filled[row][col] = 1'b1;
		else if (act == ACT_WRITE_B)
			b_filled[row][col] = 1'b1;
	endtask

	// A read in range is preceded by writes of any element of its row and column still unset.
	task automatic push_read(int row, int col);
		if (row < clamp_size(rows_cfg) && col < clamp_size(cols_cfg)) begin
			for (int k = 0; k < clamp_size(inner_cfg); k++) begin
				if (!a_filled[row][k])
					push_item(ACT_WRITE_A, row, k, rand_value());
				if (!b_filled[k][col])
					push_item(ACT_WRITE_B, k, col, rand_value());
			end
		end
		push_item(ACT_READ, row, col, VALUE_BITS'($urandom));
	endtask

	task automatic push_random(int count);
		int nr;
		int nk;
		int nc;
		nr = clamp_size(rows_cfg);
		nk = clamp_size(inner_cfg);
		nc = clamp_size(cols_cfg);
		repeat (count) begin
			case ($urandom_range(0, 19))
				0, 1, 2, 3: push_item(ACT_WRITE_A, pick_index(nr), pick_index(nk), rand_value());
				4, 5, 6, 7: push_item(ACT_WRITE_B, pick_index(nk), pick_index(nc), rand_value());
				8: push_item(ACT_UNUSED, $urandom_range(0, DIM - 1), $urandom_range(0, DIM - 1),
					VALUE_BITS'($urandom));
				default: push_read(pick_index(nr), pick_index(nc));
			endcase
		end
	endtask

	task automatic wait_idle();
		while (pending_requests.size() != 0 || req_ch.valid || expected_products.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_BITS-1:0] value);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		case (idx)
			REG_ROWS_A: rows_cfg = value;
			REG_INNER_SIZE: inner_cfg = value;
			REG_COLS_B: cols_cfg = value;
			default: ;
		endcase
	endtask

	task automatic set_sizes(logic [CFG_BITS-1:0] rows, logic [CFG_BITS-1:0] inner,
			logic [CFG_BITS-1:0] cols);
		wait_idle();
		set_reg(REG_ROWS_A, rows);
		set_reg(REG_INNER_SIZE, inner);
		set_reg(REG_COLS_B, cols);
		@(posedge clk);
		cfg_write <= 1'b0;
	endtask

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == LIMIT_CYCLES) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// Request driver: a request offered is held until the block takes it.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			req_ch.action <= ACT_WRITE_A;
			req_ch.row_index <= '0;
			req_ch.col_index <= '0;
			req_ch.element_value <= '0;
			gap_left <= 0;
			gap_stretch <= 0;
			gaps_on <= 1'b0;
		end else begin
			if (gap_stretch == 0) begin
				gap_stretch <= $urandom_range(40, 300);
				gaps_on <= ($urandom_range(0, 2) != 0);
			end else begin
				gap_stretch <= gap_stretch - 1;
			end
			if (req_ch.valid && !req_ch.ready) begin
			end else if (gap_left != 0) begin
				req_ch.valid <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (gaps_on && !calm && $urandom_range(0, 5) == 0) begin
				req_ch.valid <= 1'b0;
				gap_left <= $urandom_range(0, 12);
			end else if (pending_requests.size() != 0) begin
				next_req = pending_requests.pop_front();
				req_ch.valid <= 1'b1;
				req_ch.action <= next_req.action;
				req_ch.row_index <= next_req.row;
				req_ch.col_index <= next_req.col;
				req_ch.element_value <= next_req.value;
			end else begin
				req_ch.valid <= 1'b0;
			end
		end
	end

	// One long hold-off of the response side, so that the block fills and stalls requests.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if (!hold_done && accepted_count >= HOLD_AT) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			stall_left <= 0;
			stall_stretch <= 0;
			stalls_on <= 1'b0;
		end else begin
			if (stall_stretch == 0) begin
				stall_stretch <= $urandom_range(40, 300);
				stalls_on <= ($urandom_range(0, 2) != 0);
			end else begin
				stall_stretch <= stall_stretch - 1;
			end
			if (hold_left != 0) begin
				rsp_ch.ready <= 1'b0;
			end else if (stall_left != 0) begin
				rsp_ch.ready <= 1'b0;
				stall_left <= stall_left - 1;
			end else if (stalls_on && !calm && $urandom_range(0, 5) == 0) begin
				rsp_ch.ready <= 1'b0;
				stall_left <= $urandom_range(0, 12);
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	// Each accepted request updates the predictor; each response is checked in order.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accepted_count <= 0;
		end else begin
			if (req_ch.valid && req_ch.ready) begin
				accepted_count <= accepted_count + 1;
				case (req_ch.action)
					ACT_WRITE_A: a_mem[req_ch.row_index][req_ch.col_index] = req_ch.element_value;
					ACT_WRITE_B: b_mem[req_ch.row_index][req_ch.col_index] = req_ch.element_value;
					ACT_READ: expected_products.push_back(
						dot_product(int'(req_ch.row_index), int'(req_ch.col_index)));
					default: ;
				endcase
			end
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (expected_products.size() == 0) begin
					if (mismatch_count < 10)
						$display("unexpected product: value %0d, index_error %0b",
							rsp_ch.product_value, rsp_ch.index_error);
					mismatch_count++;
				end else begin
					want = expected_products.pop_front();
					if (rsp_ch.product_value !== want.product ||
							rsp_ch.index_error !== want.index_error) begin
						if (mismatch_count < 10)
							$display("product mismatch: expected %0d/%0b, got %0d/%0b",
								want.product, want.index_error,
								rsp_ch.product_value, rsp_ch.index_error);
						mismatch_count++;
					end
				end
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_write = 1'b0;
		cfg_index = REG_ROWS_A;
		cfg_data = '0;
		calm = 1'b0;
		rows_cfg = CFG_RESET;
		inner_cfg = CFG_RESET;
		cols_cfg = CFG_RESET;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		set_sizes(5'd2, 5'd2, 5'd2);
		push_item(ACT_WRITE_A, 0, 0, 16'sh7fff);
		push_item(ACT_WRITE_A, 0, 1, 16'sh8000);
		push_item(ACT_WRITE_B, 0, 0, 16'sh8000);
		push_item(ACT_WRITE_B, 1, 0, 16'sh8000);
		push_read(0, 0);
		push_item(ACT_WRITE_B, 0, 1, 16'sh7fff);
		push_item(ACT_WRITE_B, 1, 1, 16'sh7fff);
		push_read(0, 1);
		push_item(ACT_WRITE_A, 1, 0, -16'sd1);
		push_item(ACT_WRITE_A, 1, 1, 16'sd1);
		push_read(1, 1);
		push_read(2, 0);
		push_read(0, 2);
		push_read(15, 15);
		// The unused action must leave the stores untouched.
		push_item(ACT_UNUSED, 0, 0, -16'sd1);
		push_read(0, 0);
		push_item(ACT_WRITE_A, 15, 15, 16'sh5555);
		push_item(ACT_WRITE_B, 15, 15, 16'shaaaa);

		set_sizes(5'd0, 5'd0, 5'd0);
		push_read(0, 0);
		push_read(15, 15);
		set_sizes(5'd1, 5'd0, 5'd1);
		push_read(0, 0);
		push_read(0, 1);

		set_sizes(5'd31, 5'd31, 5'd31);
		push_random(250);
		set_sizes(5'd1, 5'd1, 5'd1);
		push_random(150);
		repeat (4) begin
			set_sizes(rand_size(), rand_size(), rand_size());
			push_random(175);
		end
		set_sizes(5'd16, 5'd16, 5'd16);
		calm = 1'b1;
		push_random(250);

		wait_idle();
		if (mismatch_count == 0 && expected_products.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

FILE: files.f
rtl/core/mme_pkg.sv
rtl/core/mme_if.sv
rtl/core/mme_ram.sv
rtl/core/mme_mac.sv
rtl/core/matrix_multiply_engine.sv
rtl/core/mme_checker.sv
bench/tb_top.sv
